>>> src/ftpcls_pkg.sv
// Types, codes and command tree tables for the FTP session classifier.
`timescale 1ns / 1ps

package ftpcls_pkg;

  // Event codes
  localparam logic [1:0] OP_COMMAND  = 2'd0;
  localparam logic [1:0] OP_PASSWORD = 2'd1;
  localparam logic [1:0] OP_USERNAME = 2'd2;
  localparam logic [1:0] OP_END      = 2'd3;

  // Verdict codes
  localparam logic [1:0] V_UNKNOWN = 2'd0;
  localparam logic [1:0] V_MATCH   = 2'd1;
  localparam logic [1:0] V_NOMATCH = 2'd2;

  // Tree size and flag constants
  localparam int unsigned NODES     = 10;
  localparam logic [7:0] ZERO_INIT  = 8'd255;
  localparam logic [7:0] ZERO_CLEAR = 8'd254;
  localparam logic [7:0] FLAG_MASK  = 8'd127;
  localparam logic [7:0] FALSE_XOR  = 8'h80;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] session_id;
    logic [3:0]  command_code;
    logic        password_is_default;
  } item_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic       session_found;
    logic       table_full;
  } result_t;

  // One row of the session table
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [3:0]  pos;
    logic [7:0]  assist;
    logic [7:0]  zero;
    logic [1:0]  verdict;
  } entry_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_EXEC  = 5'b01000,
    ST_WALK  = 5'b10000
  } state_t;

  // Next node on a false branch
  function automatic logic [3:0] node_false(input logic [3:0] p);
    logic [3:0] r;
    case (p)
      4'd2:    r = 4'd3;
      4'd6:    r = 4'd7;
      4'd8:    r = 4'd8;
      default: r = 4'd9;
    endcase
    return r;
  endfunction

  // Next node on a true branch
  function automatic logic [3:0] node_true(input logic [3:0] p);
    logic [3:0] r;
    case (p)
      4'd0:    r = 4'd1;
      4'd1:    r = 4'd2;
      4'd2:    r = 4'd3;
      4'd3:    r = 4'd4;
      4'd4:    r = 4'd5;
      4'd5:    r = 4'd6;
      4'd6:    r = 4'd7;
      4'd7:    r = 4'd8;
      4'd8:    r = 4'd8;
      default: r = 4'd9;
    endcase
    return r;
  endfunction

  // Assist flags toggled at each node (none in this tree)
  function automatic logic [7:0] node_assist(input logic [3:0] p);
    logic [7:0] r;
    case (p)
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // Decision held by a node
  function automatic logic [1:0] node_kind(input logic [3:0] p);
    logic [1:0] r;
    case (p)
      4'd8:    r = V_MATCH;
      4'd9:    r = V_NOMATCH;
      default: r = V_UNKNOWN;
    endcase
    return r;
  endfunction

  // Whether a node tests a command at all
  function automatic logic node_tested(input logic [3:0] p);
    return (p < 4'd8);
  endfunction

  // Command tested at a node: nodes 0..7 test commands 0..7
  function automatic logic [3:0] node_cmd(input logic [3:0] p);
    return p;
  endfunction

endpackage

>>> src/ftp_session_command_classifier.sv
// Top level: session table search, update and command tree walk.
// Start to done: serial table search over one memory read port, a decision
// step, then up to ten tree steps.
// busy stays high for the whole item; the next item may start in the cycle
// done is shown. The receiver cannot stall: each result is shown for one cycle.
// Reset: synchronous; a clearing pass over all SESSIONS rows follows, busy high.
`timescale 1ns / 1ps

module ftp_session_command_classifier #(
  parameter int unsigned SESSIONS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ftpcls_pkg::item_t  item,
  output logic               done,
  output ftpcls_pkg::result_t result
);

  localparam int unsigned AW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int unsigned CW = $clog2(SESSIONS + 1);
  localparam logic [AW-1:0] LAST = AW'(SESSIONS - 1);

  ftpcls_pkg::state_t state;
  logic [CW-1:0]      scan_cnt;
  logic               cmp_vld;
  logic [AW-1:0]      cmp_idx;
  logic               hit;
  logic [AW-1:0]      hit_idx;
  logic               free_found;
  logic [AW-1:0]      free_idx;
  ftpcls_pkg::entry_t row;
  ftpcls_pkg::item_t  item_q;
  logic [3:0]         p;
  logic [7:0]         a;
  logic [7:0]         zero_q;
  logic               wb;
  logic [AW-1:0]      wb_idx;
  logic               full_q;
  logic [3:0]         step_cnt;

  // Session table memory
  ftpcls_pkg::entry_t mem [SESSIONS];
  ftpcls_pkg::entry_t rd_data;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  ftpcls_pkg::entry_t wr_data;

  // Walk step signals
  logic               node_hit;
  logic [3:0]         p_next;
  logic [7:0]         a_next;
  logic [1:0]         kind_next;
  logic [1:0]         v_next;
  logic               walk_end;
  logic [3:0]         start_pos;

  assign busy = (state != ftpcls_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign rd_addr = (scan_cnt < CW'(SESSIONS)) ? scan_cnt[AW-1:0] : '0;

  // Stored position folded into the tree
  assign start_pos = (row.pos >= 4'(ftpcls_pkg::NODES)) ?
                     row.pos - 4'(ftpcls_pkg::NODES) : row.pos;

  // One tree step
  always_comb begin
    node_hit = ftpcls_pkg::node_tested(p) &&
               (item_q.command_code == ftpcls_pkg::node_cmd(p));
    if (node_hit) begin
      p_next = ftpcls_pkg::node_true(p);
      a_next = a ^ ftpcls_pkg::node_assist(p);
    end else begin
      p_next = ftpcls_pkg::node_false(p);
      if ((ftpcls_pkg::node_assist(p) & ftpcls_pkg::FALSE_XOR) == ftpcls_pkg::FALSE_XOR) begin
        a_next = a ^ ftpcls_pkg::node_assist(p);
      end else begin
        a_next = a;
      end
    end
    kind_next = ftpcls_pkg::node_kind(p_next);
    case (kind_next)
      ftpcls_pkg::V_MATCH: begin
        v_next = ((a_next & zero_q & ftpcls_pkg::FLAG_MASK) == 8'd0) ?
                 ftpcls_pkg::V_MATCH : ftpcls_pkg::V_NOMATCH;
      end
      ftpcls_pkg::V_NOMATCH: v_next = ftpcls_pkg::V_NOMATCH;
      default:               v_next = ftpcls_pkg::V_UNKNOWN;
    endcase
    walk_end = (kind_next != ftpcls_pkg::V_UNKNOWN) || node_hit ||
               (step_cnt == 4'(ftpcls_pkg::NODES - 1));
  end

  // Table write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hit_idx;
    wr_data = row;
    case (state)
      ftpcls_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = scan_cnt[AW-1:0];
        wr_data = '0;
      end
      ftpcls_pkg::ST_EXEC: begin
        if (hit && item_q.op == ftpcls_pkg::OP_PASSWORD && item_q.password_is_default) begin
          wr_en        = 1'b1;
          wr_data.zero = row.zero & ftpcls_pkg::ZERO_CLEAR;
        end else if (hit && item_q.op == ftpcls_pkg::OP_END) begin
          wr_en         = 1'b1;
          wr_data.valid = 1'b0;
        end
      end
      ftpcls_pkg::ST_WALK: begin
        if (walk_end && wb) begin
          wr_en           = 1'b1;
          wr_addr         = wb_idx;
          wr_data.valid   = 1'b1;
          wr_data.key     = item_q.session_id;
          wr_data.pos     = p_next;
          wr_data.assist  = a_next;
          wr_data.zero    = zero_q;
          wr_data.verdict = v_next;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ftpcls_pkg::ST_CLEAR;
      scan_cnt <= '0;
      cmp_vld  <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ftpcls_pkg::ST_CLEAR: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt[AW-1:0] == LAST) begin
            state <= ftpcls_pkg::ST_IDLE;
          end
        end
        ftpcls_pkg::ST_IDLE: begin
          if (start) begin
            item_q     <= item;
            scan_cnt   <= '0;
            cmp_vld    <= 1'b0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            state      <= ftpcls_pkg::ST_SCAN;
          end
        end
        ftpcls_pkg::ST_SCAN: begin
          // issue next read address
          if (scan_cnt < CW'(SESSIONS)) begin
            scan_cnt <= scan_cnt + 1'b1;
            cmp_vld  <= 1'b1;
            cmp_idx  <= scan_cnt[AW-1:0];
          end else begin
            cmp_vld <= 1'b0;
          end
          // compare the row read last cycle
          if (cmp_vld) begin
            if (rd_data.valid && rd_data.key == item_q.session_id) begin
              hit     <= 1'b1;
              hit_idx <= cmp_idx;
              row     <= rd_data;
              cmp_vld <= 1'b0;
              state   <= ftpcls_pkg::ST_EXEC;
            end else begin
              if (!rd_data.valid && !free_found) begin
                free_found <= 1'b1;
                free_idx   <= cmp_idx;
              end
              if (cmp_idx == LAST) begin
                cmp_vld <= 1'b0;
                state   <= ftpcls_pkg::ST_EXEC;
              end
            end
          end
        end
        ftpcls_pkg::ST_EXEC: begin
          result.session_found <= hit;
          result.table_full    <= 1'b0;
          case (item_q.op)
            ftpcls_pkg::OP_COMMAND: begin
              if (hit && row.verdict != ftpcls_pkg::V_UNKNOWN) begin
                result.verdict <= row.verdict;
                done           <= 1'b1;
                state          <= ftpcls_pkg::ST_IDLE;
              end else begin
                p        <= hit ? start_pos : 4'd0;
                a        <= hit ? row.assist : 8'd0;
                zero_q   <= hit ? row.zero : ftpcls_pkg::ZERO_INIT;
                wb       <= hit || free_found;
                wb_idx   <= hit ? hit_idx : free_idx;
                full_q   <= !hit && !free_found;
                step_cnt <= '0;
                state    <= ftpcls_pkg::ST_WALK;
              end
            end
            ftpcls_pkg::OP_PASSWORD, ftpcls_pkg::OP_USERNAME: begin
              result.verdict <= hit ? row.verdict : ftpcls_pkg::V_NOMATCH;
              done           <= 1'b1;
              state          <= ftpcls_pkg::ST_IDLE;
            end
            default: begin
              result.verdict <= ftpcls_pkg::V_UNKNOWN;
              done           <= 1'b1;
              state          <= ftpcls_pkg::ST_IDLE;
            end
          endcase
        end
        ftpcls_pkg::ST_WALK: begin
          p        <= p_next;
          a        <= a_next;
          step_cnt <= step_cnt + 1'b1;
          if (walk_end) begin
            result.verdict       <= v_next;
            result.session_found <= hit;
            result.table_full    <= full_q;
            done                 <= 1'b1;
            state                <= ftpcls_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= ftpcls_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ftpcls_pkg::ST_EXEC || state == ftpcls_pkg::ST_WALK))
    else $error("result strobe without a finishing step");

  a_no_wr_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ftpcls_pkg::ST_SCAN) |-> !wr_en)
    else $error("table written during search");

  a_start_scan: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ftpcls_pkg::ST_SCAN))
    else $error("accepted transfer did not start a search");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ftpcls_pkg::ST_WALK) |-> (step_cnt < 4'(ftpcls_pkg::NODES)))
    else $error("tree walk overran its bound");

  a_full_vs_found: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.table_full && result.session_found))
    else $error("full table reported for an existing session");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the FTP session command classifier.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned SESSIONS = 64;
  localparam int NTRACKS = 6;
  localparam int NOISE_KEYS = 24;

  // FTP command codes
  localparam logic [3:0] CMD_USER  = 4'd0;
  localparam logic [3:0] CMD_PASS  = 4'd1;
  localparam logic [3:0] CMD_CWD   = 4'd2;
  localparam logic [3:0] CMD_TYPE  = 4'd3;
  localparam logic [3:0] CMD_SIZE  = 4'd4;
  localparam logic [3:0] CMD_PASV  = 4'd5;
  localparam logic [3:0] CMD_REST  = 4'd6;
  localparam logic [3:0] CMD_RETR  = 4'd7;
  localparam logic [3:0] CMD_OTHER = 4'd8;
  localparam logic [3:0] CMD_MAX   = 4'd15;

  // Command tree, node 9 in the top nibble / byte
  localparam logic [39:0] FALSE_NEXT = {4'd9, 4'd8, 4'd9, 4'd7, 4'd9,
                                        4'd9, 4'd9, 4'd3, 4'd9, 4'd9};
  localparam logic [39:0] TRUE_NEXT  = {4'd9, 4'd8, 4'd8, 4'd7, 4'd6,
                                        4'd5, 4'd4, 4'd3, 4'd2, 4'd1};
  localparam logic [79:0] NODE_ASSIST = '0;
  localparam logic [3:0] MATCH_NODE  = 4'd8;
  localparam logic [3:0] REJECT_NODE = 4'd9;

  localparam logic [31:0] FILL_BASE = 32'h0000_1000;

  typedef struct packed {
    logic [3:0] pos;
    logic [7:0] assist;
    logic [1:0] verdict;
  } tree_step_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  ftpcls_pkg::item_t   item = '0;
  logic                busy;
  logic                done;
  ftpcls_pkg::result_t result;

  // Session table as the classifier should hold it
  logic        sess_valid   [SESSIONS];
  logic [31:0] sess_key     [SESSIONS];
  logic [3:0]  sess_pos     [SESSIONS];
  logic [7:0]  sess_assist  [SESSIONS];
  logic [7:0]  sess_zero    [SESSIONS];
  logic [1:0]  sess_verdict [SESSIONS];

  ftpcls_pkg::result_t pending_results[$];
  int                  mismatch_count = 0;
  int                  idle_pct = 0;

  // Scripted client sessions and a pool of reused stray keys
  logic [31:0] trk_key  [NTRACKS];
  int          trk_step [NTRACKS];
  logic [31:0] noise_keys [NOISE_KEYS];

  ftp_session_command_classifier #(.SESSIONS(SESSIONS)) uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always #5 clk = ~clk;

  // Walk the tree from one position for one command
  function automatic tree_step_t walk_tree(logic [3:0] pos0, logic [7:0] assist0,
                                           logic [7:0] zero, logic [3:0] cmd);
    tree_step_t w;
    logic [3:0] p;
    logic [7:0] a;
    logic [7:0] na;
    logic [1:0] v;
    logic       took_false;
    logic       stop;
    p = 4'(pos0 % ftpcls_pkg::NODES);
    a = assist0;
    v = ftpcls_pkg::V_UNKNOWN;
    stop = 1'b0;
    for (int g = 0; g < ftpcls_pkg::NODES && !stop; g++) begin
      na = NODE_ASSIST[p*8 +: 8];
      if (p < MATCH_NODE && cmd == p) begin
        a = a ^ na;
        p = TRUE_NEXT[p*4 +: 4];
        took_false = 1'b0;
      end else begin
        if ((na & ftpcls_pkg::FALSE_XOR) == ftpcls_pkg::FALSE_XOR) a = a ^ na;
        p = FALSE_NEXT[p*4 +: 4];
        took_false = 1'b1;
      end
      if (p == MATCH_NODE) begin
        v = ((a & zero & ftpcls_pkg::FLAG_MASK) == 8'd0) ?
            ftpcls_pkg::V_MATCH : ftpcls_pkg::V_NOMATCH;
        stop = 1'b1;
      end else if (p == REJECT_NODE) begin
        v = ftpcls_pkg::V_NOMATCH;
        stop = 1'b1;
      end else begin
        v = ftpcls_pkg::V_UNKNOWN;
        if (!took_false) stop = 1'b1;
      end
    end
    w.pos = p;
    w.assist = a;
    w.verdict = v;
    return w;
  endfunction

  // Apply one event to the table and give the result it should produce
  function automatic ftpcls_pkg::result_t classify_event(ftpcls_pkg::item_t ev);
    ftpcls_pkg::result_t r;
    tree_step_t          w;
    int                  idx;
    int                  slot;
    idx = -1;
    for (int i = 0; i < SESSIONS; i++)
      if (idx < 0 && sess_valid[i] && sess_key[i] == ev.session_id) idx = i;
    r.verdict = ftpcls_pkg::V_UNKNOWN;
    r.session_found = (idx >= 0);
    r.table_full = 1'b0;
    case (ev.op)
      ftpcls_pkg::OP_COMMAND: begin
        if (idx < 0) begin
          slot = -1;
          for (int i = 0; i < SESSIONS; i++)
            if (slot < 0 && !sess_valid[i]) slot = i;
          if (slot >= 0) begin
            idx = slot;
            sess_valid[slot] = 1'b1;
            sess_key[slot] = ev.session_id;
            sess_pos[slot] = 4'd0;
            sess_assist[slot] = 8'd0;
            sess_zero[slot] = ftpcls_pkg::ZERO_INIT;
            sess_verdict[slot] = ftpcls_pkg::V_UNKNOWN;
          end else begin
            // no room: walk a throwaway session, store nothing
            r.table_full = 1'b1;
            w = walk_tree(4'd0, 8'd0, ftpcls_pkg::ZERO_INIT, ev.command_code);
            r.verdict = w.verdict;
          end
        end else if (sess_verdict[idx] != ftpcls_pkg::V_UNKNOWN) begin
          // final verdict sticks
          r.verdict = sess_verdict[idx];
          idx = -1;
        end
        if (idx >= 0) begin
          w = walk_tree(sess_pos[idx], sess_assist[idx], sess_zero[idx], ev.command_code);
          sess_pos[idx] = w.pos;
          sess_assist[idx] = w.assist;
          sess_verdict[idx] = w.verdict;
          r.verdict = w.verdict;
        end
      end
      ftpcls_pkg::OP_PASSWORD, ftpcls_pkg::OP_USERNAME: begin
        if (idx < 0) begin
          r.verdict = ftpcls_pkg::V_NOMATCH;
        end else begin
          if (ev.op == ftpcls_pkg::OP_PASSWORD && ev.password_is_default)
            sess_zero[idx] = sess_zero[idx] & ftpcls_pkg::ZERO_CLEAR;
          r.verdict = sess_verdict[idx];
        end
      end
      default: begin
        if (idx >= 0) sess_valid[idx] = 1'b0;
      end
    endcase
    return r;
  endfunction

  // Offer one event, wait for the transfer, record what should come back
  task automatic send_event(input logic [1:0] op, input logic [31:0] id,
                            input logic [3:0] cmd, input logic pdef);
    ftpcls_pkg::item_t ev;
    ev.op = op;
    ev.session_id = id;
    ev.command_code = cmd;
    ev.password_is_default = pdef;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= ev;
    do @(posedge clk); while (busy);
    pending_results.push_back(classify_event(ev));
  endtask

  // Occasionally replace a scripted command with any code at all
  function automatic logic [3:0] maybe_garble(logic [3:0] cmd);
    return ($urandom_range(99) < 8) ? 4'($urandom_range(CMD_MAX)) : cmd;
  endfunction

  // Next event of one scripted client session
  task automatic advance_session(input int t);
    logic [31:0] k;
    logic [3:0]  junk;
    k = trk_key[t];
    junk = 4'($urandom_range(CMD_MAX));
    // CWD and REST are optional in the tree
    if ((trk_step[t] == 3 || trk_step[t] == 7) && $urandom_range(1)) trk_step[t]++;
    case (trk_step[t])
      0: send_event(ftpcls_pkg::OP_COMMAND, k, maybe_garble(CMD_USER), 1'($urandom_range(1)));
      1: send_event(ftpcls_pkg::OP_PASSWORD, k, junk, 1'($urandom_range(1)));
      2: send_event(ftpcls_pkg::OP_COMMAND, k, maybe_garble(CMD_PASS), 1'b0);
      3: send_event(ftpcls_pkg::OP_COMMAND, k, maybe_garble(CMD_CWD), 1'b0);
      4: send_event(ftpcls_pkg::OP_COMMAND, k, maybe_garble(CMD_TYPE), 1'b0);
      5: send_event(ftpcls_pkg::OP_COMMAND, k, maybe_garble(CMD_SIZE), 1'b0);
      6: send_event(ftpcls_pkg::OP_COMMAND, k, maybe_garble(CMD_PASV), 1'b0);
      7: send_event(ftpcls_pkg::OP_COMMAND, k, maybe_garble(CMD_REST), 1'b0);
      8: send_event(ftpcls_pkg::OP_COMMAND, k, maybe_garble(CMD_RETR), 1'b0);
      9: begin
        if ($urandom_range(1))
          send_event(ftpcls_pkg::OP_USERNAME, k, junk, 1'($urandom_range(1)));
        else
          send_event(ftpcls_pkg::OP_COMMAND, k, junk, 1'b0);
      end
      default: send_event(ftpcls_pkg::OP_END, k, junk, 1'($urandom_range(1)));
    endcase
    if (trk_step[t] >= 10) begin
      trk_step[t] = 0;
      trk_key[t] = $urandom();
    end else begin
      trk_step[t]++;
    end
  endtask

  // Password, username and end for sessions never seen
  task automatic test_unknown_sessions();
    idle_pct = 0;
    send_event(ftpcls_pkg::OP_PASSWORD, 32'h0000_0000, CMD_MAX, 1'b1);
    send_event(ftpcls_pkg::OP_USERNAME, 32'hFFFF_FFFF, CMD_USER, 1'b0);
    send_event(ftpcls_pkg::OP_END, 32'h0000_0000, CMD_OTHER, 1'b1);
  endtask

  // Full login and download with every optional command, then sticky match
  task automatic test_full_walk();
    logic [31:0] k;
    k = 32'hFFFF_FFFF;
    send_event(ftpcls_pkg::OP_COMMAND, k, CMD_USER, 1'b0);
    send_event(ftpcls_pkg::OP_PASSWORD, k, CMD_MAX, 1'b1);
    send_event(ftpcls_pkg::OP_COMMAND, k, CMD_PASS, 1'b0);
    send_event(ftpcls_pkg::OP_COMMAND, k, CMD_CWD, 1'b0);
    send_event(ftpcls_pkg::OP_COMMAND, k, CMD_TYPE, 1'b0);
    send_event(ftpcls_pkg::OP_COMMAND, k, CMD_SIZE, 1'b0);
    send_event(ftpcls_pkg::OP_COMMAND, k, CMD_PASV, 1'b0);
    send_event(ftpcls_pkg::OP_COMMAND, k, CMD_REST, 1'b0);
    send_event(ftpcls_pkg::OP_COMMAND, k, CMD_RETR, 1'b1);
    send_event(ftpcls_pkg::OP_USERNAME, k, CMD_OTHER, 1'b0);
    send_event(ftpcls_pkg::OP_COMMAND, k, CMD_USER, 1'b0);
    send_event(ftpcls_pkg::OP_END, k, CMD_USER, 1'b0);
    send_event(ftpcls_pkg::OP_END, k, CMD_USER, 1'b0);
  endtask

  // Rejections, skipped optional nodes and codes above the named ones
  task automatic test_tree_branches();
    send_event(ftpcls_pkg::OP_COMMAND, 32'h0000_0000, CMD_OTHER, 1'b0);
    send_event(ftpcls_pkg::OP_COMMAND, 32'h0000_0000, CMD_USER, 1'b0);
    send_event(ftpcls_pkg::OP_COMMAND, 32'h0000_0001, CMD_USER, 1'b0);
    send_event(ftpcls_pkg::OP_COMMAND, 32'h0000_0001, CMD_PASS, 1'b0);
    send_event(ftpcls_pkg::OP_COMMAND, 32'h0000_0001, CMD_TYPE, 1'b0);
    send_event(ftpcls_pkg::OP_COMMAND, 32'h0000_0001, CMD_SIZE, 1'b0);
    send_event(ftpcls_pkg::OP_COMMAND, 32'h0000_0001, CMD_PASV, 1'b0);
    send_event(ftpcls_pkg::OP_COMMAND, 32'h0000_0001, CMD_RETR, 1'b0);
    send_event(ftpcls_pkg::OP_COMMAND, 32'h0000_0002, CMD_MAX, 1'b0);
    send_event(ftpcls_pkg::OP_END, 32'h0000_0000, CMD_OTHER, 1'b0);
    send_event(ftpcls_pkg::OP_END, 32'h0000_0001, CMD_OTHER, 1'b0);
    send_event(ftpcls_pkg::OP_END, 32'h0000_0002, CMD_OTHER, 1'b0);
  endtask

  // Fill every slot, overflow, free one slot and reuse it
  task automatic test_table_full();
    idle_pct = 24;
    for (int i = 0; i < SESSIONS; i++)
      send_event(ftpcls_pkg::OP_COMMAND, FILL_BASE + 32'(i), CMD_USER, 1'b0);
    send_event(ftpcls_pkg::OP_COMMAND, 32'hDEAD_0001, CMD_USER, 1'b0);
    send_event(ftpcls_pkg::OP_COMMAND, 32'hDEAD_0002, CMD_RETR, 1'b0);
    send_event(ftpcls_pkg::OP_PASSWORD, 32'hDEAD_0001, CMD_USER, 1'b1);
    send_event(ftpcls_pkg::OP_END, FILL_BASE + 32'd5, CMD_USER, 1'b0);
    send_event(ftpcls_pkg::OP_COMMAND, 32'hDEAD_0001, CMD_USER, 1'b0);
    send_event(ftpcls_pkg::OP_COMMAND, FILL_BASE + 32'd6, CMD_PASS, 1'b0);
    for (int i = 0; i < SESSIONS; i++)
      if (i != 5) send_event(ftpcls_pkg::OP_END, FILL_BASE + 32'(i), CMD_USER, 1'b0);
    send_event(ftpcls_pkg::OP_END, 32'hDEAD_0001, CMD_USER, 1'b0);
  endtask

  // Mostly scripted sessions, the rest stray events
  task automatic random_traffic(input int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 80) begin
        advance_session($urandom_range(NTRACKS - 1));
      end else begin
        send_event(2'($urandom_range(3)),
                   (roll < 90) ? noise_keys[$urandom_range(NOISE_KEYS - 1)] : $urandom(),
                   4'($urandom_range(CMD_MAX)), 1'($urandom_range(1)));
      end
    end
  endtask

  // Random traffic under several sender idling patterns
  task automatic test_random();
    for (int t = 0; t < NTRACKS; t++) begin
      trk_key[t] = $urandom();
      trk_step[t] = 0;
    end
    for (int i = 0; i < NOISE_KEYS; i++) noise_keys[i] = $urandom();
    idle_pct = 0;
    random_traffic(175);
    idle_pct = 70;
    random_traffic(175);
    idle_pct = 24;
    random_traffic(175);
    for (int b = 0; b < 7; b++) begin
      idle_pct = $urandom_range(1) ? 70 : 0;
      random_traffic(25);
    end
  endtask

  // Compare every result transfer with the oldest prediction
  // (fields shown as verdict/found/full)
  always @(posedge clk) begin
    ftpcls_pkg::result_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d",
                 $time, result.verdict, result.session_found, result.table_full);
      end else begin
        exp_r = pending_results.pop_front();
        if (result.verdict !== exp_r.verdict ||
            result.session_found !== exp_r.session_found ||
            result.table_full !== exp_r.table_full) begin
          mismatch_count++;
          $display("%0t: expected %0d/%0d/%0d, actual %0d/%0d/%0d",
                   $time, exp_r.verdict, exp_r.session_found, exp_r.table_full,
                   result.verdict, result.session_found, result.table_full);
        end
      end
    end
  end

  initial begin
    int guard;
    for (int i = 0; i < SESSIONS; i++) sess_valid[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_unknown_sessions();
    test_full_walk();
    test_tree_branches();
    test_table_full();
    test_random();
    start <= 1'b0;
    // drain, then allow time for one more item
    guard = 0;
    while (pending_results.size() != 0 && guard < 4 * (SESSIONS + 13)) begin
      @(posedge clk);
      guard++;
    end
    repeat (SESSIONS + 13) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatch_count += pending_results.size();
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
src/ftpcls_pkg.sv
src/ftp_session_command_classifier.sv
tb/sv/testbench.sv
